[rtl/stlm_pkg.sv]
// shared types, constants and the dB lookup table of the level meter
package stlm_pkg;

  // field widths fixed by the register map and result format
  localparam int COEF_W     = 17;
  localparam int HOLD_W     = 8;
  localparam int STEP_W     = 12;
  localparam int DB_W       = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // log conversion constants
  localparam int MANT_W = 20;
  localparam int TAB_W  = 11;
  localparam int OCT_DB = 394566;   // 20*log10(2) scaled by 65536
  localparam int OCT_DB_W = 19;

  localparam logic [COEF_W-1:0] COEF_ONE = 17'd65536;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd4;

  // register reset values
  localparam logic [COEF_W-1:0]      ATTACK_RST  = 17'd45875;
  localparam logic [COEF_W-1:0]      RELEASE_RST = 17'd2621;
  localparam logic [HOLD_W-1:0]      HOLD_RST    = 8'd60;
  localparam logic [STEP_W-1:0]      DECAY_RST   = 12'd128;
  localparam logic signed [DB_W-1:0] FLOOR_RST   = -16'sd15360;

  // configuration as seen by the datapath, floor already limited to 0 dB
  typedef struct packed {
    logic [COEF_W-1:0]      atk_coef;
    logic [COEF_W-1:0]      rel_coef;
    logic [HOLD_W-1:0]      hold_ticks;
    logic [STEP_W-1:0]      decay_step;
    logic signed [DB_W-1:0] floor_db;
  } stlm_cfg_t;

  // 20*log10(1 + i/16) in Q7.8
  function automatic logic [TAB_W-1:0] db_tab(input logic [4:0] idx);
    logic [TAB_W-1:0] v;
    unique case (idx)
      5'd0:    v = 11'd0;
      5'd1:    v = 11'd135;
      5'd2:    v = 11'd262;
      5'd3:    v = 11'd382;
      5'd4:    v = 11'd496;
      5'd5:    v = 11'd605;
      5'd6:    v = 11'd708;
      5'd7:    v = 11'd807;
      5'd8:    v = 11'd902;
      5'd9:    v = 11'd992;
      5'd10:   v = 11'd1080;
      5'd11:   v = 11'd1163;
      5'd12:   v = 11'd1244;
      5'd13:   v = 11'd1322;
      5'd14:   v = 11'd1398;
      5'd15:   v = 11'd1471;
      5'd16:   v = 11'd1541;
      default: v = 11'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/stlm_in_if.sv]
// input channel of the level meter: one item per meter tick
interface stlm_in_if #(parameter int LW = 17);
  logic          valid;
  logic          ready;
  logic [LW-1:0] raw_left;
  logic [LW-1:0] raw_right;

  modport source (output valid, raw_left, raw_right, input ready);
  modport sink   (input valid, raw_left, raw_right, output ready);
endinterface

[rtl/stlm_out_if.sv]
// result channel of the level meter: displayed levels, dB values, peaks and clip flags
interface stlm_out_if #(parameter int LW = 17);
  logic                             valid;
  logic                             ready;
  logic [LW-1:0]                    shown_left;
  logic [LW-1:0]                    shown_right;
  logic signed [stlm_pkg::DB_W-1:0] shown_left_db;
  logic signed [stlm_pkg::DB_W-1:0] shown_right_db;
  logic signed [stlm_pkg::DB_W-1:0] peak_left_db;
  logic signed [stlm_pkg::DB_W-1:0] peak_right_db;
  logic                             clip_left;
  logic                             clip_right;

  modport source (output valid, shown_left, shown_right, shown_left_db, shown_right_db,
                  peak_left_db, peak_right_db, clip_left, clip_right, input ready);
  modport sink   (input valid, shown_left, shown_right, shown_left_db, shown_right_db,
                  peak_left_db, peak_right_db, clip_left, clip_right, output ready);
endinterface

[rtl/stlm_ballistic.sv]
// one channel's attack/release step of the displayed linear level
module stlm_ballistic #(
  parameter int LFB = 16
) (
  input  logic [LFB:0]                  raw,
  input  logic [LFB:0]                  level,
  input  logic [stlm_pkg::COEF_W-1:0]   atk_coef,
  input  logic [stlm_pkg::COEF_W-1:0]   rel_coef,
  output logic [LFB:0]                  level_nxt
);
  import stlm_pkg::*;

  localparam int LW = LFB + 1;
  localparam int PW = LW + COEF_W;
  localparam logic [LW-1:0] ONE = {1'b1, {LFB{1'b0}}};

  logic [LW-1:0]     raw_c;
  logic              rise;
  logic [LW-1:0]     gap;
  logic [COEF_W-1:0] coef_sel;
  logic [COEF_W-1:0] coef;
  logic [PW-1:0]     prod;
  logic [PW-1:0]     rnd;
  logic [LW-1:0]     step;
  logic [LW:0]       sum;

  // clamp raw level and pick direction
  assign raw_c    = (raw > ONE) ? ONE : raw;
  assign rise     = raw_c > level;
  assign gap      = rise ? (raw_c - level) : (level - raw_c);
  assign coef_sel = rise ? atk_coef : rel_coef;
  assign coef     = (coef_sel > COEF_ONE) ? COEF_ONE : coef_sel;

  // fraction of the gap, rounded half up
  assign prod = {{COEF_W{1'b0}}, gap} * {{LW{1'b0}}, coef};
  assign rnd  = prod + PW'(32768);
  assign step = rnd[16 +: LW];

  // move toward raw and keep within 0..full scale
  assign sum = {1'b0, level} + {1'b0, step};

  always_comb begin
    if (rise) begin
      level_nxt = (sum > {1'b0, ONE}) ? ONE : sum[LW-1:0];
    end else begin
      level_nxt = (level >= step) ? (level - step) : '0;
    end
  end

endmodule

[rtl/stlm_log_db.sv]
// linear level to 20*log10 in Q7.8 by leading-one position and table interpolation
module stlm_log_db #(
  parameter int LFB = 16
) (
  input  logic [LFB:0]                      level,
  input  logic signed [stlm_pkg::DB_W-1:0]  floor_db,
  output logic signed [stlm_pkg::DB_W-1:0]  db
);
  import stlm_pkg::*;

  localparam int LW    = LFB + 1;
  localparam int PW    = $clog2(LW);
  localparam int WW    = LW + MANT_W - 1;
  localparam int OCT_W = PW + OCT_DB_W;
  localparam int NEG_W = OCT_W + 2;

  logic [PW-1:0]           p;
  logic [WW-1:0]           wide;
  logic [MANT_W-1:0]       mant;
  logic [3:0]              idx;
  logic [14:0]             rem;
  logic [TAB_W-1:0]        tab_lo;
  logic [TAB_W-1:0]        tab_hi;
  logic [TAB_W-1:0]        tab_diff;
  logic [7:0]              diff;
  logic [23:0]             ip_prod;
  logic [16:0]             interp;
  logic [19:0]             fterm;
  logic [PW-1:0]           oct;
  logic [OCT_W-1:0]        oct_term;
  logic signed [NEG_W-1:0] neg;
  logic [NEG_W-1:0]        rnd;
  logic signed [NEG_W-1:0] db_full;
  logic signed [NEG_W-1:0] floor_ext;

  // leading-one position
  always_comb begin
    p = '0;
    for (int b = 0; b < LW; b++) begin
      if (level[b]) begin
        p = PW'(b);
      end
    end
  end

  // normalize so the leading one sits at the mantissa msb
  assign wide = {level, {(MANT_W-1){1'b0}}} >> p;
  assign mant = wide[MANT_W-1:0];
  assign idx  = mant[18:15];
  assign rem  = mant[14:0];

  // table lookup and linear interpolation in Q7.16
  assign tab_lo   = db_tab({1'b0, idx});
  assign tab_hi   = db_tab({1'b0, idx} + 5'd1);
  assign tab_diff = tab_hi - tab_lo;
  assign diff     = tab_diff[7:0];
  assign ip_prod  = ({16'd0, diff} * {9'd0, rem}) + 24'd64;
  assign interp   = ip_prod[23:7];
  assign fterm    = {1'b0, tab_lo, 8'd0} + {3'd0, interp};

  // octave term minus fraction term gives the attenuation magnitude
  assign oct      = PW'(LFB) - p;
  assign oct_term = {{OCT_DB_W{1'b0}}, oct} * OCT_W'(OCT_DB);
  assign neg      = $signed(NEG_W'(oct_term)) - $signed(NEG_W'(fterm));
  assign rnd      = neg + NEG_W'(128);

  // round to Q7.8, cap at 0 dB, raise to the floor
  assign floor_ext = $signed({{(NEG_W-DB_W){floor_db[DB_W-1]}}, floor_db});
  assign db_full   = (neg > 0) ? -$signed(NEG_W'(rnd[NEG_W-1:8])) : '0;

  always_comb begin
    if (level == '0) begin
      db = floor_db;
    end else if (db_full < floor_ext) begin
      db = floor_db;
    end else begin
      db = db_full[DB_W-1:0];
    end
  end

endmodule

[rtl/stlm_peak.sv]
// one channel's peak hold and decay update
module stlm_peak (
  input  logic signed [stlm_pkg::DB_W-1:0]   db,
  input  logic signed [stlm_pkg::DB_W-1:0]   peak,
  input  logic [stlm_pkg::HOLD_W-1:0]        hold,
  input  stlm_pkg::stlm_cfg_t                cfg,
  output logic signed [stlm_pkg::DB_W-1:0]   peak_nxt,
  output logic [stlm_pkg::HOLD_W-1:0]        hold_nxt
);
  import stlm_pkg::*;

  logic signed [DB_W:0] fallen;
  logic signed [DB_W:0] floor_ext;

  assign fallen    = $signed({peak[DB_W-1], peak}) - $signed({{(DB_W+1-STEP_W){1'b0}},
                                                               cfg.decay_step});
  assign floor_ext = $signed({cfg.floor_db[DB_W-1], cfg.floor_db});

  // new peak reloads hold, else count down, else decay toward the floor
  always_comb begin
    peak_nxt = peak;
    hold_nxt = hold;
    if (db > peak) begin
      peak_nxt = db;
      hold_nxt = cfg.hold_ticks;
    end else if (hold != '0) begin
      hold_nxt = hold - 1'b1;
    end else if (fallen < floor_ext) begin
      peak_nxt = cfg.floor_db;
    end else begin
      peak_nxt = fallen[DB_W-1:0];
    end
  end

endmodule

[rtl/stereo_level_meter_ballistics.sv]
// top level of the stereo level meter: config registers, three-stage pipeline, two channels
// Stereo level meter ballistics. Each item is one meter tick carrying the raw left and right
// levels (unsigned Q1.LEVEL_FRAC_BITS). The block accepts one item per clock cycle while the
// output is not stalled and offers one result per item, passed through these stages in order:
// an input register, the level register (attack/release step, this register is also the
// channel's level state), and the result register (dB conversion and peak hold, the peak
// registers are the held-peak state). A full output register stalls the pipeline stage by
// stage through ready. Configuration registers are written through cfg_we/cfg_index/cfg_data
// and must only change while no item is in flight; an unknown index is ignored.
module stereo_level_meter_ballistics #(
  parameter int LEVEL_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  stlm_in_if.sink                           in_ch,
  stlm_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [stlm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stlm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import stlm_pkg::*;

  localparam int LW = LEVEL_FRAC_BITS + 1;

  // configuration registers
  logic [COEF_W-1:0]      atk_coef_r;
  logic [COEF_W-1:0]      rel_coef_r;
  logic [HOLD_W-1:0]      hold_ticks_r;
  logic [STEP_W-1:0]      decay_step_r;
  logic signed [DB_W-1:0] floor_db_r;
  stlm_cfg_t              cfg;

  // pipeline control
  logic v0_r, v1_r, v2_r;
  logic acc_in, adv1, adv2;

  // stage payload and state
  logic [LW-1:0]          raw_l_r, raw_r_r;
  logic [LW-1:0]          level_l_r, level_r_r;
  logic [LW-1:0]          level_l_nxt, level_r_nxt;
  logic signed [DB_W-1:0] db_l, db_r;
  logic signed [DB_W-1:0] peak_l_r, peak_r_r;
  logic signed [DB_W-1:0] peak_l_nxt, peak_r_nxt;
  logic [HOLD_W-1:0]      hold_l_r, hold_r_r;
  logic [HOLD_W-1:0]      hold_l_nxt, hold_r_nxt;
  logic [LW-1:0]          shown_l_r, shown_r_r;
  logic signed [DB_W-1:0] db_l_r, db_r_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atk_coef_r   <= ATTACK_RST;
      rel_coef_r   <= RELEASE_RST;
      hold_ticks_r <= HOLD_RST;
      decay_step_r <= DECAY_RST;
      floor_db_r   <= FLOOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTACK:  atk_coef_r   <= cfg_data;
        REG_RELEASE: rel_coef_r   <= cfg_data;
        REG_HOLD:    hold_ticks_r <= cfg_data[HOLD_W-1:0];
        REG_DECAY:   decay_step_r <= cfg_data[STEP_W-1:0];
        REG_FLOOR:   floor_db_r   <= $signed(cfg_data[DB_W-1:0]);
        default: ;
      endcase
    end
  end

  // a positive floor acts as 0 dB
  always_comb begin
    cfg.atk_coef   = atk_coef_r;
    cfg.rel_coef   = rel_coef_r;
    cfg.hold_ticks = hold_ticks_r;
    cfg.decay_step = decay_step_r;
    cfg.floor_db   = floor_db_r[DB_W-1] ? floor_db_r : '0;
  end

  // handshake and stage advance
  assign adv2         = v1_r && (!v2_r || out_ch.ready);
  assign adv1         = v0_r && (!v1_r || adv2);
  assign in_ch.ready  = !v0_r || adv1;
  assign acc_in       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (acc_in) begin
        v0_r <= 1'b1;
      end else if (adv1) begin
        v0_r <= 1'b0;
      end
      if (adv1) begin
        v1_r <= 1'b1;
      end else if (adv2) begin
        v1_r <= 1'b0;
      end
      if (adv2) begin
        v2_r <= 1'b1;
      end else if (out_ch.ready) begin
        v2_r <= 1'b0;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (acc_in) begin
      raw_l_r <= in_ch.raw_left;
      raw_r_r <= in_ch.raw_right;
    end
  end

  // ballistic step per channel
  stlm_ballistic #(.LFB(LEVEL_FRAC_BITS)) u_bal_l (
    .raw       (raw_l_r),
    .level     (level_l_r),
    .atk_coef  (cfg.atk_coef),
    .rel_coef  (cfg.rel_coef),
    .level_nxt (level_l_nxt)
  );

  stlm_ballistic #(.LFB(LEVEL_FRAC_BITS)) u_bal_r (
    .raw       (raw_r_r),
    .level     (level_r_r),
    .atk_coef  (cfg.atk_coef),
    .rel_coef  (cfg.rel_coef),
    .level_nxt (level_r_nxt)
  );

  // level state doubles as the second stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_l_r <= '0;
      level_r_r <= '0;
    end else if (adv1) begin
      level_l_r <= level_l_nxt;
      level_r_r <= level_r_nxt;
    end
  end

  // dB conversion per channel
  stlm_log_db #(.LFB(LEVEL_FRAC_BITS)) u_log_l (
    .level    (level_l_r),
    .floor_db (cfg.floor_db),
    .db       (db_l)
  );

  stlm_log_db #(.LFB(LEVEL_FRAC_BITS)) u_log_r (
    .level    (level_r_r),
    .floor_db (cfg.floor_db),
    .db       (db_r)
  );

  // peak hold per channel
  stlm_peak u_peak_l (
    .db       (db_l),
    .peak     (peak_l_r),
    .hold     (hold_l_r),
    .cfg      (cfg),
    .peak_nxt (peak_l_nxt),
    .hold_nxt (hold_l_nxt)
  );

  stlm_peak u_peak_r (
    .db       (db_r),
    .peak     (peak_r_r),
    .hold     (hold_r_r),
    .cfg      (cfg),
    .peak_nxt (peak_r_nxt),
    .hold_nxt (hold_r_nxt)
  );

  // peak and hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_l_r <= FLOOR_RST;
      peak_r_r <= FLOOR_RST;
      hold_l_r <= '0;
      hold_r_r <= '0;
    end else if (adv2) begin
      peak_l_r <= peak_l_nxt;
      peak_r_r <= peak_r_nxt;
      hold_l_r <= hold_l_nxt;
      hold_r_r <= hold_r_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv2) begin
      shown_l_r <= level_l_r;
      shown_r_r <= level_r_r;
      db_l_r    <= db_l;
      db_r_r    <= db_r;
    end
  end

  // result channel
  assign out_ch.valid          = v2_r;
  assign out_ch.shown_left     = shown_l_r;
  assign out_ch.shown_right    = shown_r_r;
  assign out_ch.shown_left_db  = db_l_r;
  assign out_ch.shown_right_db = db_r_r;
  assign out_ch.peak_left_db   = peak_l_r;
  assign out_ch.peak_right_db  = peak_r_r;
  assign out_ch.clip_left      = !db_l_r[DB_W-1];
  assign out_ch.clip_right     = !db_r_r[DB_W-1];

endmodule
